[rtl/srl_pkg.sv]
// ----------------------------------------------------------------------------
// srl_pkg: shared types and constants of the segmented RMS loudness meter
// Holds the sequencer state type, the command and status bundles between
// sequencer and datapath, the register indexes and the format codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

	// Field and datapath widths
	localparam int WORD_W  = 32;
	localparam int LEVEL_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int FMT_W   = 2;
	localparam int CNT_W   = 16;
	localparam int SUM_W   = 47;
	localparam int MAG_W   = 17;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int ROOT_W  = (SUM_W + 1) / 2;
	localparam int RREM_W  = ROOT_W + 3;
	localparam int DREM_W  = CNT_W + 1;
	localparam int ITER_W  = 6;

	// One quotient bit per divide step, one root bit per root step
	localparam int DIV_STEPS  = SUM_W;
	localparam int ROOT_STEPS = ROOT_W;

	// Full-scale magnitude in units of 1/32768
	localparam logic [MAG_W-1:0] MAG_FULL = 17'd32768;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 2'd1;

	// Reset values of the registers
	localparam logic [FMT_W-1:0] FMT_RESET = 2'd1;
	localparam logic [CNT_W-1:0] LEN_RESET = 16'd1470;

	// Sample format codes
	localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_F32 = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_ROOT_LD,
		ST_ROOT,
		ST_OUT
	} state_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load_in;
		logic do_mul;
		logic do_acc;
		logic div_step;
		logic root_load;
		logic root_step;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic seg_end;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/srl_if.sv]
// ----------------------------------------------------------------------------
// srl_if: channel interfaces of the segmented RMS loudness meter
// Sample input channel, level output channel and configuration write
// channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface srl_in_if import srl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] sample_word;

	modport source (output valid, output sample_word, input ready);
	modport sink   (input valid, input sample_word, output ready);
endinterface

interface srl_out_if import srl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] rms_level;

	modport source (output valid, output rms_level, input ready);
	modport sink   (input valid, input rms_level, output ready);
endinterface

interface srl_cfg_if import srl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/srl_ctrl.sv]
// ----------------------------------------------------------------------------
// srl_ctrl: sequencer of the segmented RMS loudness meter
// Steps one sample through square and accumulate, and at a segment end
// through the iterative divide, the iterative root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_ctrl import srl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t            state_q;
	state_t            state_d;
	logic [ITER_W-1:0] iter_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step counter, restarted on every state change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (state_q != state_d) begin
			iter_q <= '0;
		end else begin
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = sts.seg_end ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
					state_d = ST_ROOT_LD;
				end
			end
			ST_ROOT_LD: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (iter_q == ITER_W'(ROOT_STEPS - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
			end
			ST_ACC: begin
				cmd.do_acc = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_ROOT_LD: begin
				cmd.root_load = 1'b1;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// The divide never runs past its last quotient bit.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (iter_q < ITER_W'(DIV_STEPS)))
		else $error("divide ran past its last step");

	// A segment end always starts the divide.
	a_seg_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && sts.seg_end) |=> (state_q == ST_DIV))
		else $error("segment end did not start the divide");

	// An accepted sample always goes on to the squaring step.
	a_load_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == ST_MUL))
		else $error("accepted sample was not squared");

endmodule

`default_nettype wire

[rtl/srl_dp.sv]
// ----------------------------------------------------------------------------
// srl_dp: datapath of the segmented RMS loudness meter
// Sample conversion, squaring, accumulation, a restoring divider, a
// digit-by-digit square root with rounding, the output register and the
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_dp import srl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [WORD_W-1:0] in_word,
	srl_cfg_if.sink                cfg,
	srl_out_if.source              levels
);

	// Magnitude of a float32 pattern in units of 1/32768, clamped to full scale
	function automatic logic [MAG_W-1:0] float_mag(input logic [WORD_W-1:0] w);
		logic [7:0]  e;
		logic [22:0] m;
		logic [7:0]  sh;
		logic [24:0] mant;
		logic [24:0] rnd;
		logic [MAG_W-1:0] res;
		e    = w[30:23];
		m    = w[22:0];
		sh   = 8'd135 - e;
		mant = {2'b01, m};
		rnd  = mant + (25'd1 << (sh[4:0] - 5'd1));
		if (e == 8'hFF && m != 23'd0) begin
			res = '0;
		end else if (e >= 8'd127) begin
			res = MAG_FULL;
		end else if (e == 8'd0 || sh >= 8'd25) begin
			res = '0;
		end else begin
			res = MAG_W'(rnd >> sh[4:0]);
		end
		return res;
	endfunction

	// Magnitude of the converted sample; an unused format code reads as zero
	function automatic logic [MAG_W-1:0] sample_mag(input logic [WORD_W-1:0] w,
			input logic [FMT_W-1:0] fmt);
		logic [7:0]        b;
		logic signed [8:0] v9;
		logic [8:0]        a9;
		logic signed [16:0] h17;
		logic [16:0]       a17;
		logic [MAG_W-1:0]  res;
		b   = w[7:0] ^ 8'h80;
		v9  = {b[7], b};
		a9  = v9[8] ? 9'(-v9) : 9'(v9);
		h17 = {w[15], w[15:0]};
		a17 = h17[16] ? 17'(-h17) : 17'(h17);
		case (fmt)
			FMT_U8:  res = {a9, 8'b0};
			FMT_S16: res = a17;
			FMT_F32: res = float_mag(w);
			default: res = '0;
		endcase
		return res;
	endfunction

	logic [FMT_W-1:0]  fmt_q;
	logic [CNT_W-1:0]  len_q;
	logic [MAG_W-1:0]  mag_s1;
	logic [SQ_W-1:0]   sq_s2;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_nxt;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [CNT_W-1:0]  len_eff;
	logic              seg_end;
	logic [SUM_W-1:0]  dvd_q;
	logic [DREM_W-1:0] drem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [DREM_W-1:0] drem_sh;
	logic              dge;
	logic [2*ROOT_W-1:0] rx_q;
	logic [ROOT_W-1:0] root_q;
	logic [RREM_W-1:0] rrem_q;
	logic [RREM_W-1:0] rrem_sh;
	logic [RREM_W-1:0] trial;
	logic              rge;
	logic [ROOT_W-1:0] root_rnd;
	logic [LEVEL_W-1:0] level_q;
	logic              out_valid_q;

	// Configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RESET;
			len_q <= LEN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SAMPLE_FORMAT:  fmt_q <= cfg.data[FMT_W-1:0];
				REG_SEGMENT_LENGTH: len_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Conversion on the accepted beat, then squaring
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_s1 <= sample_mag(in_word, fmt_q);
		end
		if (cmd.do_mul) begin
			sq_s2 <= mag_s1 * mag_s1;
		end
	end

	// Accumulation and segment end detection
	assign sum_nxt = sum_q + SUM_W'(sq_s2);
	assign cnt_nxt = cnt_q + CNT_W'(1);
	assign len_eff = (len_q == '0) ? CNT_W'(1) : len_q;
	assign seg_end = (cnt_nxt != '0) && (cnt_nxt >= len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.do_acc) begin
			if (seg_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	// Restoring divider, one quotient bit per step shifted into the dividend
	assign drem_sh = {drem_q[DREM_W-2:0], dvd_q[SUM_W-1]};
	assign dge     = drem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.do_acc && seg_end) begin
			dvd_q  <= sum_nxt;
			drem_q <= '0;
			dvs_q  <= cnt_nxt;
		end else if (cmd.div_step) begin
			drem_q <= dge ? (drem_sh - {1'b0, dvs_q}) : drem_sh;
			dvd_q  <= {dvd_q[SUM_W-2:0], dge};
		end
	end

	// Square root, one root bit per step from two radicand bits
	assign rrem_sh = {rrem_q[RREM_W-3:0], rx_q[2*ROOT_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rge     = rrem_sh >= trial;

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rx_q   <= (2*ROOT_W)'(dvd_q);
			root_q <= '0;
			rrem_q <= '0;
		end else if (cmd.root_step) begin
			rx_q   <= {rx_q[2*ROOT_W-3:0], 2'b00};
			rrem_q <= rge ? (rrem_sh - trial) : rrem_sh;
			root_q <= {root_q[ROOT_W-2:0], rge};
		end
	end

	// Round to nearest: the remainder is the mean minus the floored root squared
	assign root_rnd = root_q + ROOT_W'(rrem_q > RREM_W'(root_q));

	// Output register
	assign sts.out_free = !out_valid_q || levels.ready;
	assign sts.seg_end  = seg_end;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q <= root_rnd[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (levels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign levels.valid     = out_valid_q;
	assign levels.rms_level = level_q;

	// A segment end leaves an empty segment behind.
	a_seg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_acc && seg_end) |=> (cnt_q == '0 && sum_q == '0))
		else $error("segment end did not clear the accumulator");

	// A level never exceeds full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_q <= LEVEL_W'(MAG_FULL)))
		else $error("level above full scale");

	// A waiting level is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && out_valid_q) |-> levels.ready)
		else $error("waiting level overwritten");

endmodule

`default_nettype wire

[rtl/segmented_rms_loudness.sv]
// ----------------------------------------------------------------------------
// segmented_rms_loudness: windowed RMS level meter
// Converts each sample to a fraction of full scale, sums the squares over a
// segment and delivers the rounded root of the floored mean per segment.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                 Beat
//   samples   in    sample_word[31:0]       one raw sample
//   levels    out   rms_level[15:0]         one segment level
//   cfg       in    index[1:0], data[15:0]  one register write
//
// A sample passes through accept and convert, square and accumulate in turn,
// since the single multiplier and the wide accumulator add are separate steps.
// The last sample of a segment adds 47 divide steps, one root load and 24
// root steps, one bit each, then the load of the output
// register, which waits only while a previous level has not been taken.
// Reset clears the sum, the count and the registers to their reset values.
//
`default_nettype none

module segmented_rms_loudness import srl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	srl_in_if.sink    samples,
	srl_out_if.source levels,
	srl_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign samples.ready = in_ready;

	srl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srl_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_word (samples.sample_word),
		.cfg     (cfg),
		.levels  (levels)
	);

endmodule

`default_nettype wire
